/* rtl/psc_pkg.sv */
`default_nettype none
package psc_pkg;

    localparam int unsigned CFG_ADDR_W   = 5;
    localparam int unsigned CFG_DATA_W   = 32;
    localparam logic [6:0]  THRESH_CAP   = 7'd120;
    localparam logic [6:0]  SCORE_CAP    = 7'd127;
    localparam logic [15:0] COUNT_MAX    = 16'hffff;
    localparam logic [5:0]  REEMIT_LAST  = 6'd59;
    localparam logic [7:0]  TOGETHER_ADD = 8'd20;

    typedef enum logic [2:0] {
        REG_MOTION_THR  = 3'd0,
        REG_ACTIVE_THR  = 3'd1,
        REG_BREATH_THR  = 3'd2,
        REG_PET_MODE    = 3'd3,
        REG_PET_WINDOWS = 3'd4,
        REG_SHIM_SWING  = 3'd5,
        REG_SHIM_FLOOR  = 3'd6,
        REG_SHIM_ENABLE = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_EMPTY    = 3'd0,
        ST_SUBTLE   = 3'd1,
        ST_QUIET    = 3'd2,
        ST_ACTIVE   = 3'd3,
        ST_TOGETHER = 3'd4
    } t_state;

    typedef enum logic [1:0] {
        CONF_TENTATIVE = 2'd0,
        CONF_OBSERVED  = 2'd1,
        CONF_CONFIRMED = 2'd2
    } t_conf;

    typedef enum logic [1:0] {
        DOM_NONE      = 2'd0,
        DOM_MOTION    = 2'd1,
        DOM_BREATHING = 2'd2
    } t_dom;

    typedef enum logic {
        OP_WINDOW  = 1'b0,
        OP_DISMISS = 1'b1
    } t_op;

    typedef struct packed {
        logic              operation;
        logic signed [7:0] doppler_0;
        logic signed [7:0] doppler_1;
        logic signed [7:0] doppler_2;
        logic signed [7:0] doppler_3;
        logic signed [7:0] rssi_high;
        logic signed [7:0] rssi_low;
        logic [6:0]        breathing_peak;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  presence_state;
        logic [1:0]  confidence;
        logic [1:0]  dominant;
        logic [6:0]  move_level;
        logic [6:0]  breath_level;
        logic [15:0] windows_count;
    } t_out_item;

    typedef struct packed {
        logic [6:0]  move_thr;
        logic [6:0]  act_thr;
        logic [6:0]  breath_thr;
        logic        pet_gate;
        logic [15:0] pet_required_windows;
        logic [7:0]  shimmer_swing;
        logic [7:0]  shimmer_motion_floor;
        logic        shimmer_enable;
    } t_cfg;

    typedef struct packed {
        logic       dismiss;
        logic       shimmer;
        logic [6:0] motion;
        logic [6:0] breathing;
    } t_cls;

    function automatic logic [6:0] nudged(input logic [6:0] base, input logic [6:0] nudge);
        logic [7:0] sum;
        sum = {1'b0, base} + {1'b0, nudge};
        if (base >= THRESH_CAP) begin
            return base;
        end else if (sum > {1'b0, THRESH_CAP}) begin
            return THRESH_CAP;
        end else begin
            return sum[6:0];
        end
    endfunction

endpackage
`default_nettype wire

/* rtl/psc_cfg.sv */
`default_nettype none
module psc_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [psc_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [psc_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [psc_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                pready,
    output psc_pkg::t_cfg                       o_cfg
);
    import psc_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[CFG_ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                REG_MOTION_THR:  n_cfg.move_thr             = pwdata[6:0];
                REG_ACTIVE_THR:  n_cfg.act_thr              = pwdata[6:0];
                REG_BREATH_THR:  n_cfg.breath_thr           = pwdata[6:0];
                REG_PET_MODE:    n_cfg.pet_gate             = pwdata[0];
                REG_PET_WINDOWS: n_cfg.pet_required_windows = pwdata[15:0];
                REG_SHIM_SWING:  n_cfg.shimmer_swing        = pwdata[7:0];
                REG_SHIM_FLOOR:  n_cfg.shimmer_motion_floor = pwdata[7:0];
                REG_SHIM_ENABLE: n_cfg.shimmer_enable       = pwdata[0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            REG_MOTION_THR:  prdata[6:0]  = r_cfg.move_thr;
            REG_ACTIVE_THR:  prdata[6:0]  = r_cfg.act_thr;
            REG_BREATH_THR:  prdata[6:0]  = r_cfg.breath_thr;
            REG_PET_MODE:    prdata[0]    = r_cfg.pet_gate;
            REG_PET_WINDOWS: prdata[15:0] = r_cfg.pet_required_windows;
            REG_SHIM_SWING:  prdata[7:0]  = r_cfg.shimmer_swing;
            REG_SHIM_FLOOR:  prdata[7:0]  = r_cfg.shimmer_motion_floor;
            REG_SHIM_ENABLE: prdata[0]    = r_cfg.shimmer_enable;
            default:         prdata       = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.move_thr             <= 7'd35;
            r_cfg.act_thr              <= 7'd75;
            r_cfg.breath_thr           <= 7'd30;
            r_cfg.pet_gate             <= 1'b0;
            r_cfg.pet_required_windows <= 16'd30;
            r_cfg.shimmer_swing        <= 8'd8;
            r_cfg.shimmer_motion_floor <= 8'd30;
            r_cfg.shimmer_enable       <= 1'b1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule
`default_nettype wire

/* rtl/psc_front.sv */
`default_nettype none
module psc_front (
    input  wire psc_pkg::t_in_item i_item,
    input  wire psc_pkg::t_cfg     i_cfg,
    output psc_pkg::t_cls          o_cls
);
    import psc_pkg::*;

    logic [7:0]        w_abs [4];
    logic [9:0]        w_sum;
    logic [6:0]        w_motion;
    logic signed [9:0] w_swing;
    logic signed [9:0] w_swing_lim;

    function automatic logic [7:0] mag8(input logic signed [7:0] d);
        return d[7] ? (~d + 8'd1) : d;
    endfunction

    assign w_abs[0] = mag8(i_item.doppler_0);
    assign w_abs[1] = mag8(i_item.doppler_1);
    assign w_abs[2] = mag8(i_item.doppler_2);
    assign w_abs[3] = mag8(i_item.doppler_3);

    assign w_sum = {2'b0, w_abs[0]} + {2'b0, w_abs[1]} + {2'b0, w_abs[2]} + {2'b0, w_abs[3]};
    assign w_motion = w_sum[9] ? SCORE_CAP : w_sum[8:2];

    assign w_swing     = 10'(i_item.rssi_high) - 10'(i_item.rssi_low);
    assign w_swing_lim = $signed({2'b00, i_cfg.shimmer_swing});

    assign o_cls.dismiss   = (i_item.operation == OP_DISMISS);
    assign o_cls.shimmer   = i_cfg.shimmer_enable && (w_swing > w_swing_lim)
                             && ({1'b0, w_motion} < i_cfg.shimmer_motion_floor);
    assign o_cls.motion    = w_motion;
    assign o_cls.breathing = i_item.breathing_peak;

endmodule
`default_nettype wire

/* rtl/psc_queue.sv */
`default_nettype none
module psc_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire psc_pkg::t_cls i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output psc_pkg::t_cls      o_data
);
    import psc_pkg::*;

    t_cls       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule
`default_nettype wire

/* rtl/psc_back.sv */
`default_nettype none
module psc_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire psc_pkg::t_cfg  i_cfg,
    input  wire logic           i_valid,
    input  wire psc_pkg::t_cls  i_cls,
    output logic                o_take,
    output logic                o_empty,
    input  wire logic           i_pop,
    output psc_pkg::t_out_item  o_item
);
    import psc_pkg::*;

    t_state      r_cur,   n_cur;
    logic [15:0] r_win,   n_win;
    logic [5:0]  r_mod,   n_mod;
    t_state      r_pend,  n_pend;
    logic [1:0]  r_pcnt,  n_pcnt;
    logic [6:0]  r_nudge, n_nudge;

    t_out_item   r_buf [2];
    logic        r_owr;
    logic        r_ord;
    logic [1:0]  r_ocnt;

    t_state      w_tgt;
    logic [7:0]  w_gate;
    logic [1:0]  w_pcnt_new;
    logic        w_emit;
    logic        w_opop;
    logic [6:0]  w_mag;
    t_out_item   w_res;

    assign o_take  = i_valid && (r_ocnt != 2'd2);
    assign w_opop  = i_pop && (r_ocnt != 2'd0);
    assign o_empty = (r_ocnt == 2'd0);
    assign o_item  = r_buf[r_ord];

    always_comb begin
        w_gate = {1'b0, i_cfg.act_thr} + TOGETHER_ADD;
        if (w_gate > {1'b0, SCORE_CAP}) begin
            w_gate = {1'b0, SCORE_CAP};
        end
        if (i_cls.shimmer) begin
            w_tgt = ST_EMPTY;
        end else if ({1'b0, i_cls.motion} >= w_gate && r_win >= 16'd5) begin
            w_tgt = ST_TOGETHER;
        end else if (i_cls.motion >= i_cfg.act_thr) begin
            w_tgt = ST_ACTIVE;
        end else if (i_cls.breathing >= nudged(i_cfg.breath_thr, r_nudge)) begin
            w_tgt = (i_cfg.pet_gate && r_win < i_cfg.pet_required_windows) ?
                    ST_SUBTLE : ST_QUIET;
        end else if (i_cls.motion >= nudged(i_cfg.move_thr, r_nudge)) begin
            w_tgt = ST_SUBTLE;
        end else begin
            w_tgt = ST_EMPTY;
        end
    end

    always_comb begin
        n_cur      = r_cur;
        n_win      = r_win;
        n_mod      = r_mod;
        n_pend     = r_pend;
        n_pcnt     = r_pcnt;
        n_nudge    = r_nudge;
        w_emit     = 1'b0;
        w_pcnt_new = r_pcnt;
        if (o_take) begin
            if (i_cls.dismiss) begin
                if (r_nudge < THRESH_CAP) begin
                    n_nudge = r_nudge + 7'd1;
                end
            end else if (w_tgt != r_cur) begin
                if (w_tgt != r_pend) begin
                    w_pcnt_new = 2'd1;
                end else if (r_pcnt < 2'd3) begin
                    w_pcnt_new = r_pcnt + 2'd1;
                end
                n_pend = w_tgt;
                n_pcnt = w_pcnt_new;
                if (w_pcnt_new >= 2'd2) begin
                    n_cur  = w_tgt;
                    n_win  = '0;
                    n_mod  = '0;
                    n_pcnt = '0;
                    w_emit = 1'b1;
                end
            end else begin
                if (r_win != COUNT_MAX) begin
                    n_win = r_win + 16'd1;
                    n_mod = (r_mod == REEMIT_LAST) ? 6'd0 : r_mod + 6'd1;
                end
                w_emit = (n_win == 16'd5) || (n_win == 16'd20) || (n_mod == 6'd0);
            end
        end
    end

    always_comb begin
        w_mag = (i_cls.motion >= i_cls.breathing) ? i_cls.motion : i_cls.breathing;
        w_res.presence_state  = n_cur;
        if (n_win >= 16'd20 && w_mag >= 7'd60) begin
            w_res.confidence = CONF_CONFIRMED;
        end else if (n_win >= 16'd3) begin
            w_res.confidence = CONF_OBSERVED;
        end else begin
            w_res.confidence = CONF_TENTATIVE;
        end
        if (n_cur == ST_EMPTY) begin
            w_res.dominant = DOM_NONE;
        end else if (i_cls.motion >= i_cls.breathing) begin
            w_res.dominant = DOM_MOTION;
        end else begin
            w_res.dominant = DOM_BREATHING;
        end
        w_res.move_level    = i_cls.motion;
        w_res.breath_level  = i_cls.breathing;
        w_res.windows_count = n_win;
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_buf[r_owr] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= ST_EMPTY;
            r_win   <= '0;
            r_mod   <= '0;
            r_pend  <= ST_EMPTY;
            r_pcnt  <= '0;
            r_nudge <= '0;
            r_owr   <= 1'b0;
            r_ord   <= 1'b0;
            r_ocnt  <= 2'd0;
        end else begin
            r_cur   <= n_cur;
            r_win   <= n_win;
            r_mod   <= n_mod;
            r_pend  <= n_pend;
            r_pcnt  <= n_pcnt;
            r_nudge <= n_nudge;
            if (w_emit) begin
                r_owr <= ~r_owr;
            end
            if (w_opop) begin
                r_ord <= ~r_ord;
            end
            r_ocnt <= r_ocnt + {1'b0, w_emit} - {1'b0, w_opop};
        end
    end

endmodule
`default_nettype wire

/* rtl/presence_state_classifier_top.sv */
// Presence state classifier.
// Input channel: drive i_item and raise push; a transaction completes on a
// clock edge with push high and full low. Each item is a feature window or
// a dismiss nudge (operation high), which raises only move_thr and breath_thr.
// Result channel: while empty is low, o_item holds the oldest result; a
// transaction completes on a clock edge with pop high and empty low.
// A window produces zero or one result; a dismiss produces none.
// Throughput: one item per cycle, sustained while results are drained.
// Path: an item is classified as it is taken and written into the middle
// queue; the state update then takes it from the queue and writes its result
// into the two-entry buffer, from which o_item shows it until it is popped.
// When pop stays low the result buffer fills, the state update stalls, the
// middle queue fills and full rises; nothing is dropped.
// Configuration goes through the APB-style port, one register per 4 bytes;
// the user writes it only while the block is idle; the block does not enforce this.
// Reset (i_rst_n low, synchronous) restores register defaults, clears the
// state to empty with zero counts and nudge, and empties both queues.
`default_nettype none
module presence_state_classifier_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [psc_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [psc_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [psc_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                pready,
    input  wire logic                           push,
    output logic                                full,
    input  wire psc_pkg::t_in_item              i_item,
    output logic                                empty,
    input  wire logic                           pop,
    output psc_pkg::t_out_item                  o_item
);
    import psc_pkg::*;

    t_cfg w_cfg;
    t_cls w_cls_in;
    t_cls w_cls_out;
    logic w_q_valid;
    logic w_take;

    psc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    psc_front u_front (
        .i_item (i_item),
        .i_cfg  (w_cfg),
        .o_cls  (w_cls_in)
    );

    psc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (w_cls_in),
        .o_full  (full),
        .i_pop   (w_take),
        .o_valid (w_q_valid),
        .o_data  (w_cls_out)
    );

    psc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (w_q_valid),
        .i_cls   (w_cls_out),
        .o_take  (w_take),
        .o_empty (empty),
        .i_pop   (pop),
        .o_item  (o_item)
    );

endmodule
`default_nettype wire
